// ===== sv/swaf_pkg.sv =====
package swaf_pkg;

    // width of the symbol field of an input word
    localparam int unsigned SYM_BITS = 5;

    // width of the match index on the result word
    localparam int unsigned MATCH_BITS = 16;

    // input word kinds; the fourth code is unused and ignored
    typedef enum logic [1:0] {
        KIND_CLEAR   = 2'd0,
        KIND_PATTERN = 2'd1,
        KIND_TEXT    = 2'd2
    } t_kind;

    // per-step controls broadcast to every letter lane
    typedef struct packed {
        logic clear_pat;
        logic clear_win;
        logic pat_load;
        logic text_step;
        logic full;
    } t_lane_ctl;

endpackage

// ===== sv/swaf_lane.sv =====
module swaf_lane #(
    parameter int LETTER   = 0,
    parameter int CNT_BITS = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  swaf_pkg::t_lane_ctl           i_ctl,
    input  logic [swaf_pkg::SYM_BITS-1:0] i_sym,
    input  logic [swaf_pkg::SYM_BITS-1:0] i_old_sym,
    output logic                          o_eq
);
    import swaf_pkg::*;

    logic [CNT_BITS-1:0] r_pat_cnt;
    logic [CNT_BITS-1:0] n_pat_cnt;
    logic [CNT_BITS-1:0] r_win_cnt;
    logic [CNT_BITS-1:0] n_win_cnt;
    logic                hit_new;
    logic                hit_old;
    logic                dec;

    // letter decode for the incoming and the leaving symbol
    assign hit_new = (32'(i_sym) == 32'(LETTER));
    assign hit_old = (32'(i_old_sym) == 32'(LETTER));
    assign dec     = i_ctl.full && hit_old && (r_win_cnt != '0);

    // next pattern and window counts for this letter
    always_comb begin
        n_pat_cnt = r_pat_cnt;
        n_win_cnt = r_win_cnt;
        if (i_ctl.clear_pat) begin
            n_pat_cnt = '0;
        end else if (i_ctl.pat_load && hit_new) begin
            n_pat_cnt = r_pat_cnt + CNT_BITS'(1);
        end
        if (i_ctl.clear_win) begin
            n_win_cnt = '0;
        end else if (i_ctl.text_step) begin
            n_win_cnt = r_win_cnt - CNT_BITS'(dec) + CNT_BITS'(hit_new);
        end
    end

    // window agrees with the pattern on this letter after the step
    assign o_eq = (n_win_cnt == n_pat_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_cnt <= '0;
            r_win_cnt <= '0;
        end else begin
            r_pat_cnt <= n_pat_cnt;
            r_win_cnt <= n_win_cnt;
        end
    end

endmodule

// ===== sv/sliding_window_anagram_finder.sv =====
// path: an accepted text word is held in the input register and its match word in the result register
// throughput: one word per cycle while the output is not stalled; per-letter counters update in parallel lanes and the
//   leaving symbol is prefetched from the ring memory into a register ahead of its use, with write bypass
// reset: synchronous active-low i_rst_n clears counts, lengths, index and both pipeline
//   valids; the ring memory is not cleared and its contents are only used where they were written
module sliding_window_anagram_finder #(
    parameter int MAX_PATTERN   = 64,
    parameter int ALPHABET_SIZE = 26,
    parameter int INDEX_BITS    = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_kind,
    input  logic [swaf_pkg::SYM_BITS-1:0]   i_symbol,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [swaf_pkg::MATCH_BITS-1:0] o_match_start
);
    import swaf_pkg::*;

    localparam int PW = $clog2(MAX_PATTERN + 1);
    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SW = (INDEX_BITS > PW) ? INDEX_BITS : PW;

    // input register
    logic                  r_in_valid;
    logic [1:0]            r_kind;
    logic [SYM_BITS-1:0]   r_sym;

    // result register
    logic                  r_out_valid;
    logic [MATCH_BITS-1:0] r_match;

    // scalar state
    logic [PW-1:0]         r_plen;
    logic [PW-1:0]         n_plen;
    logic [PW-1:0]         r_fill;
    logic [PW-1:0]         n_fill;
    logic [INDEX_BITS-1:0] r_text_pos;
    logic [INDEX_BITS-1:0] n_text_pos;
    logic [AW-1:0]         r_ring_wr;
    logic [AW-1:0]         n_ring_wr;

    // ring of recent text symbols
    logic [SYM_BITS-1:0]   ring_mem [MAX_PATTERN];
    logic [SYM_BITS-1:0]   r_old_sym;
    logic                  ring_we;
    logic [AW:0]           rd_sum;
    logic [AW-1:0]         rd_addr;

    logic                  advance;
    logic                  commit;
    logic                  full;
    logic                  full_after;
    logic                  sym_ok;
    logic                  match;
    logic [SW-1:0]         start_full;
    logic [INDEX_BITS-1:0] start_idx;
    t_lane_ctl             lane_ctl;
    logic [ALPHABET_SIZE-1:0] lane_eq;

    // handshake: the input register refills when it is empty or the result slot can move
    assign advance    = !r_out_valid || i_out_ready;
    assign commit     = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    assign full       = (r_fill == r_plen);
    assign full_after = full || ((r_fill + PW'(1)) == r_plen);
    assign sym_ok     = (32'(r_sym) < 32'(ALPHABET_SIZE));

    // step decode and next scalar state
    always_comb begin
        lane_ctl   = '0;
        n_plen     = r_plen;
        n_fill     = r_fill;
        n_text_pos = r_text_pos;
        n_ring_wr  = r_ring_wr;
        ring_we    = 1'b0;
        if (commit) begin
            case (r_kind)
                KIND_CLEAR: begin
                    lane_ctl.clear_pat = 1'b1;
                    lane_ctl.clear_win = 1'b1;
                    n_plen     = '0;
                    n_fill     = '0;
                    n_text_pos = '0;
                    n_ring_wr  = '0;
                end
                KIND_PATTERN: begin
                    lane_ctl.clear_win = 1'b1;
                    n_fill     = '0;
                    n_text_pos = '0;
                    n_ring_wr  = '0;
                    if ((r_plen < PW'(MAX_PATTERN)) && sym_ok) begin
                        lane_ctl.pat_load = 1'b1;
                        n_plen = r_plen + PW'(1);
                    end
                end
                KIND_TEXT: begin
                    n_text_pos = r_text_pos + INDEX_BITS'(1);
                    if (r_plen != '0) begin
                        lane_ctl.text_step = 1'b1;
                        lane_ctl.full      = full;
                        ring_we            = 1'b1;
                        if (!full) begin
                            n_fill = r_fill + PW'(1);
                        end
                        if (r_ring_wr == AW'(MAX_PATTERN - 1)) begin
                            n_ring_wr = '0;
                        end else begin
                            n_ring_wr = r_ring_wr + AW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // slot that leaves the window on the next text word
    assign rd_sum  = {1'b0, n_ring_wr} + (AW + 1)'(MAX_PATTERN) - (AW + 1)'(n_plen);
    assign rd_addr = (rd_sum >= (AW + 1)'(MAX_PATTERN))
                   ? AW'(rd_sum - (AW + 1)'(MAX_PATTERN)) : AW'(rd_sum);

    // ring write and prefetched read with bypass of the word written now
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring_mem[r_ring_wr] <= r_sym;
        end
        if (ring_we && (r_ring_wr == rd_addr)) begin
            r_old_sym <= r_sym;
        end else begin
            r_old_sym <= ring_mem[rd_addr];
        end
    end

    // one counter lane per letter
    for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_lane
        swaf_lane #(
            .LETTER   (k),
            .CNT_BITS (PW)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (lane_ctl),
            .i_sym     (r_sym),
            .i_old_sym (r_old_sym),
            .o_eq      (lane_eq[k])
        );
    end

    // match detection and window start index
    assign match      = lane_ctl.text_step && full_after && (&lane_eq);
    assign start_full = SW'(r_text_pos) + SW'(1) - SW'(r_plen);
    assign start_idx  = start_full[INDEX_BITS-1:0];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_plen      <= '0;
            r_fill      <= '0;
            r_text_pos  <= '0;
            r_ring_wr   <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= match;
            end
            r_plen     <= n_plen;
            r_fill     <= n_fill;
            r_text_pos <= n_text_pos;
            r_ring_wr  <= n_ring_wr;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_kind <= i_kind;
            r_sym  <= i_symbol;
        end
        if (advance) begin
            r_match <= MATCH_BITS'(start_idx);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_start = r_match;

`ifndef SYNTHESIS
    // window never holds more words than the pattern
    a_fill_le_plen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_plen)
        else $error("window fill exceeds pattern length");

    // pattern length stays within capacity
    a_plen_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= PW'(MAX_PATTERN))
        else $error("pattern length beyond capacity");

    // ring pointer stays inside the ring
    a_ring_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ring_wr) < 32'(MAX_PATTERN))
        else $error("ring pointer out of range");

    // a new result only follows a committed text word
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !(commit && (r_kind == KIND_TEXT)) |=> !r_out_valid)
        else $error("result without a text word");

    // a clear word empties the pattern and the window
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit && (r_kind == KIND_CLEAR) |=> (r_plen == '0) && (r_fill == '0))
        else $error("clear left state behind");
`endif

endmodule
